// ----- hdl/path_deviation_checker_defines.svh -----
// Assertion macros for the path deviation checker.
`ifndef PATH_DEVIATION_CHECKER_DEFINES_SVH
`define PATH_DEVIATION_CHECKER_DEFINES_SVH

`ifndef SYNTH
`define PDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdc assertion failed");
`define PDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pdc assertion failed");
`else
`define PDC_ASSERT_NOW(label, ante, cons)
`define PDC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/pdc_pkg.sv -----
package pdc_pkg;

  localparam int MAX_WAYPOINTS = 64;
  localparam int WP_IDX_W      = $clog2(MAX_WAYPOINTS);
  localparam int PLEN_W        = 7;
  localparam int COORD_BITS    = 20;
  localparam int LIMIT_W       = 20;
  localparam int T_FRAC_BITS   = 16;
  localparam int DIST_W        = 44;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_PATH_LENGTH     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_LIMIT = 1'd1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [WP_IDX_W-1:0]   slot;
    coord_t                x;
    coord_t                y;
    coord_t                z;
  } cmd_t;

  typedef struct packed {
    logic              off_path;
    logic [DIST_W-1:0] dist_sq;
  } rslt_t;

endpackage

// ----- hdl/pdc_front.sv -----
module pdc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      action_i,
  input  logic [pdc_pkg::WP_IDX_W-1:0] slot_i,
  input  pdc_pkg::coord_t           pos_x_i,
  input  pdc_pkg::coord_t           pos_y_i,
  input  pdc_pkg::coord_t           pos_z_i,
  output logic                      cmd_valid_o,
  output pdc_pkg::cmd_t             cmd_o,
  input  logic                      cmd_pop_i
);
  import pdc_pkg::*;

  cmd_t       entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_new;
  logic       do_push, do_pop;

  always_comb begin
    cmd_new.kind = action_i ? CMD_QUERY : CMD_WRITE;
    cmd_new.slot = slot_i;
    cmd_new.x    = pos_x_i;
    cmd_new.y    = pos_y_i;
    cmd_new.z    = pos_z_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- hdl/pdc_rslt_q.sv -----
module pdc_rslt_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pdc_pkg::rslt_t rslt_i,
  output logic           full_o,
  output logic           empty,
  input  logic           pop,
  output pdc_pkg::rslt_t rslt_o
);
  import pdc_pkg::*;

  rslt_t      entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty   = (cnt_q == 2'd0);
  assign rslt_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= rslt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- hdl/pdc_back.sv -----
module pdc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  pdc_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  input  logic [pdc_pkg::PLEN_W-1:0]  path_len_i,
  input  logic [pdc_pkg::LIMIT_W-1:0] dev_limit_i,
  output logic                        rslt_push_o,
  output pdc_pkg::rslt_t              rslt_o,
  input  logic                        rslt_full_i
);
  import pdc_pkg::*;

  localparam int OP_W   = COORD_BITS + 2;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int REM_W  = PROD_W;
  localparam int LSQ_W  = 2 * LIMIT_W;
  localparam int MAG_HI = COORD_BITS + T_FRAC_BITS;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef logic signed [COORD_BITS:0] diff_t;
  typedef logic signed [OP_W-1:0]     op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LDA, ST_LDB, ST_DOT, ST_LEN, ST_CMP, ST_DIV,
    ST_OFF, ST_SQ, ST_UPD, ST_NEXT, ST_LIM, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SRC_AP, SRC_PB, SRC_D
  } src_e;

  logic [3*COORD_BITS-1:0] mem_q [MAX_WAYPOINTS];
  logic [3*COORD_BITS-1:0] rdata_q;
  logic [WP_IDX_W-1:0]     raddr;
  logic                    mem_we;

  state_e               state_q;
  src_e                 src_q;
  logic [1:0]           step_q;
  logic [1:0]           kidx;
  logic [WP_IDX_W-1:0]  seg_q;
  logic [PLEN_W-1:0]    n_q, n_sat;
  coord_t               p_q [3];
  coord_t               a_q [3];
  coord_t               b_q [3];
  coord_t               rd_c [3];
  diff_t                ab_q [3], ap_q [3], pb_q [3];
  op_t                  d_q [3];
  logic signed [ACC_W-1:0]  dot_q, acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [REM_W:0]       len_q, rem2;
  logic [REM_W-1:0]     rem_q;
  logic [T_FRAC_BITS-1:0] t_q;
  logic [3:0]           cnt_q;
  logic [DIST_W-1:0]    best_q, seg_dist_sq;
  logic                 any_q, short_q;
  logic [LSQ_W-1:0]     limsq_q;
  op_t                  opa, opb, off, sq_op;
  logic [COORD_BITS:0]  ab_mag;

  function automatic op_t mag_of(diff_t v);
    op_t e;
    e = op_t'(v);
    return v[COORD_BITS] ? -e : e;
  endfunction

  assign n_sat = (path_len_i > PLEN_W'(MAX_WAYPOINTS)) ? PLEN_W'(MAX_WAYPOINTS) : path_len_i;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign mem_we    = cmd_pop_o && (cmd_i.kind == CMD_WRITE);
  assign kidx      = (step_q == 2'd3) ? 2'd2 : step_q;

  always_comb begin
    case (state_q)
      ST_IDLE: raddr = '0;
      ST_LDA:  raddr = WP_IDX_W'(1);
      default: raddr = seg_q + WP_IDX_W'(2);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cmd_i.slot] <= {cmd_i.z, cmd_i.y, cmd_i.x};
    end
    rdata_q <= mem_q[raddr];
  end

  assign rd_c[0] = rdata_q[COORD_BITS-1:0];
  assign rd_c[1] = rdata_q[2*COORD_BITS-1:COORD_BITS];
  assign rd_c[2] = rdata_q[3*COORD_BITS-1:2*COORD_BITS];

  always_comb begin
    case (src_q)
      SRC_AP:  sq_op = op_t'(ap_q[kidx]);
      SRC_PB:  sq_op = op_t'(pb_q[kidx]);
      SRC_D:   sq_op = d_q[kidx];
      default: sq_op = '0;
    endcase
  end

  always_comb begin
    opa = '0;
    opb = '0;
    case (state_q)
      ST_DOT: begin
        opa = op_t'(ap_q[kidx]);
        opb = op_t'(ab_q[kidx]);
      end
      ST_LEN: begin
        opa = op_t'(ab_q[kidx]);
        opb = op_t'(ab_q[kidx]);
      end
      ST_OFF: begin
        opa = mag_of(ab_q[kidx]);
        opb = op_t'({1'b0, t_q});
      end
      ST_SQ: begin
        opa = sq_op;
        opb = sq_op;
      end
      ST_LIM: begin
        opa = op_t'({1'b0, dev_limit_i});
        opb = op_t'({1'b0, dev_limit_i});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // offset of the previous lane, from the registered product
  assign ab_mag = prod_q[MAG_HI:T_FRAC_BITS];
  assign off    = ab_q[step_q - 2'd1][COORD_BITS] ? -op_t'({1'b0, ab_mag})
                                                  : op_t'({1'b0, ab_mag});
  assign rem2   = {rem_q, 1'b0};
  assign seg_dist_sq = (acc_q[ACC_W-1:DIST_W] != '0) ? DIST_MAX : acc_q[DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 2'd0;
      seg_q   <= '0;
      n_q     <= '0;
      cnt_q   <= '0;
      any_q   <= 1'b0;
      short_q <= 1'b0;
      src_q   <= SRC_AP;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i && cmd_i.kind == CMD_QUERY) begin
            p_q[0] <= cmd_i.x;
            p_q[1] <= cmd_i.y;
            p_q[2] <= cmd_i.z;
            n_q    <= n_sat;
            best_q <= DIST_MAX;
            any_q  <= 1'b0;
            seg_q  <= '0;
            step_q <= 2'd0;
            if (n_sat < PLEN_W'(2)) begin
              short_q <= 1'b1;
              state_q <= ST_LIM;
            end else begin
              short_q <= 1'b0;
              state_q <= ST_LDA;
            end
          end
        end
        ST_LDA: begin
          for (int k = 0; k < 3; k++) a_q[k] <= rd_c[k];
          state_q <= ST_LDB;
        end
        ST_LDB: begin
          for (int k = 0; k < 3; k++) begin
            b_q[k]  <= rd_c[k];
            ab_q[k] <= diff_t'(rd_c[k]) - diff_t'(a_q[k]);
            ap_q[k] <= diff_t'(p_q[k]) - diff_t'(a_q[k]);
            pb_q[k] <= diff_t'(p_q[k]) - diff_t'(rd_c[k]);
          end
          step_q  <= 2'd0;
          state_q <= ST_DOT;
        end
        ST_DOT, ST_LEN, ST_SQ: begin
          if (step_q == 2'd0) begin
            acc_q <= '0;
            if (state_q == ST_LEN) dot_q <= acc_q;
          end else begin
            acc_q <= acc_q + ACC_W'(prod_q);
          end
          step_q <= step_q + 2'd1;
          if (step_q == 2'd3) begin
            case (state_q)
              ST_DOT:  state_q <= ST_LEN;
              ST_LEN:  state_q <= ST_CMP;
              default: state_q <= ST_UPD;
            endcase
          end
        end
        ST_CMP: begin
          len_q <= acc_q[REM_W:0];
          if (acc_q == '0) begin
            state_q <= ST_NEXT;
          end else if (dot_q < 0) begin
            src_q   <= SRC_AP;
            step_q  <= 2'd0;
            state_q <= ST_SQ;
          end else if (dot_q > acc_q) begin
            src_q   <= SRC_PB;
            step_q  <= 2'd0;
            state_q <= ST_SQ;
          end else begin
            rem_q   <= dot_q[REM_W-1:0];
            t_q     <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem2 >= len_q) begin
            rem_q <= REM_W'(rem2 - len_q);
            t_q   <= {t_q[T_FRAC_BITS-2:0], 1'b1};
          end else begin
            rem_q <= rem2[REM_W-1:0];
            t_q   <= {t_q[T_FRAC_BITS-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(T_FRAC_BITS - 1)) begin
            step_q  <= 2'd0;
            state_q <= ST_OFF;
          end
        end
        ST_OFF: begin
          if (step_q != 2'd0) begin
            d_q[step_q - 2'd1] <= op_t'(ap_q[step_q - 2'd1]) - off;
          end
          step_q <= step_q + 2'd1;
          if (step_q == 2'd3) begin
            src_q   <= SRC_D;
            state_q <= ST_SQ;
          end
        end
        ST_UPD: begin
          if (!any_q || seg_dist_sq < best_q) best_q <= seg_dist_sq;
          any_q   <= 1'b1;
          state_q <= ST_NEXT;
        end
        ST_NEXT: begin
          step_q <= 2'd0;
          if (PLEN_W'(seg_q) + PLEN_W'(2) >= n_q) begin
            state_q <= ST_LIM;
          end else begin
            seg_q <= seg_q + WP_IDX_W'(1);
            for (int k = 0; k < 3; k++) a_q[k] <= b_q[k];
            state_q <= ST_LDB;
          end
        end
        ST_LIM: begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd1) begin
            limsq_q <= prod_q[LSQ_W-1:0];
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!rslt_full_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rslt_push_o      = (state_q == ST_EMIT) && !rslt_full_i;
  assign rslt_o.off_path  = !short_q && (best_q > DIST_W'(limsq_q));
  assign rslt_o.dist_sq   = best_q;

endmodule

// ----- hdl/path_deviation_checker.sv -----
// Waypoint write: stored by the back end once dequeued, no result.
// Query: n = min(path_length, 64) waypoints; below two waypoints no segment is checked.
//   Uses one shared 22x22 multiplier (up to 12 products per segment) and a 16-step
//   radix-2 divider, one query at a time.
// Reset (rst_ni low, async) empties both two-deep queues, path_length = 0,
//   deviation_limit = 256; waypoint store contents stay undefined.
`include "path_deviation_checker_defines.svh"

module path_deviation_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           action_i,
  input  logic [pdc_pkg::WP_IDX_W-1:0]   slot_i,
  input  logic signed [pdc_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic signed [pdc_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic signed [pdc_pkg::COORD_BITS-1:0] pos_z_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           off_path_o,
  output logic [pdc_pkg::DIST_W-1:0]     nearest_dist_sq_o,
  input  logic                           cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import pdc_pkg::*;

  logic [PLEN_W-1:0]  path_len_q;
  logic [LIMIT_W-1:0] dev_limit_q;
  logic               cmd_valid, cmd_pop, rslt_push, rslt_full;
  cmd_t               cmd;
  rslt_t              rslt_in, rslt_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_len_q  <= '0;
      dev_limit_q <= LIMIT_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PATH_LENGTH:     path_len_q  <= cfg_wdata_i[PLEN_W-1:0];
        CFG_DEVIATION_LIMIT: dev_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  pdc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .slot_i      (slot_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .path_len_i  (path_len_q),
    .dev_limit_i (dev_limit_q),
    .rslt_push_o (rslt_push),
    .rslt_o      (rslt_in),
    .rslt_full_i (rslt_full)
  );

  pdc_rslt_q u_rslt_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rslt_push),
    .rslt_i (rslt_in),
    .full_o (rslt_full),
    .empty  (empty),
    .pop    (pop),
    .rslt_o (rslt_out)
  );

  assign off_path_o        = rslt_out.off_path;
  assign nearest_dist_sq_o = rslt_out.dist_sq;

  `PDC_ASSERT_NOW(a_no_rslt_ovf, rslt_push, !rslt_full)
  `PDC_ASSERT_NOW(a_pop_has_cmd, cmd_pop, cmd_valid)
  `PDC_ASSERT_NOW(a_off_nonzero, !empty && off_path_o, nearest_dist_sq_o != '0)

endmodule
